>>> rtl/lfu_pkg.sv
// Shared types and constants for the LFU cache engine.
package lfu_pkg;

	typedef logic signed [31:0] word_t;
	typedef logic [4:0]         cap_t;

	// Request opcodes
	localparam logic OP_GET = 1'b0;
	localparam logic OP_SET = 1'b1;

	localparam cap_t  CAP_RESET  = 5'd16;
	localparam word_t MISS_VALUE = -32'sd1;
	localparam word_t ZERO_WORD  = 32'sd0;

endpackage

>>> rtl/lfu_cache_engine_core.sv
// LFU key-value cache with LRU tie-break, one request per cycle while the consumer takes results.
//
// Each request word (opcode, req_key, req_value) is taken into an input register,
// then looked up and applied to the cache state while the result word is loaded into
// the output register; this step waits, and the request stays in the input register,
// while an earlier result still sits in the output register and has not been taken.
// A new request can be accepted every cycle; the sustained rate is one word per cycle
// whenever the consumer takes results. The input register also lets one more request
// be taken while a result waits. Per cycle the lookup compares the key against all
// MAX_ENTRIES stored keys in parallel, and a victim is chosen by a comparator tree
// over (use count, recency rank): lowest count wins, the oldest entry wins among
// equal counts. New keys go to the lowest-numbered free entry until the effective
// capacity (active_capacity, saturated to MAX_ENTRIES) is reached. Capacity zero
// turns every get into a miss and every set into a no-op. Use counts saturate at
// 2^COUNT_WIDTH-1. The capacity register is written through the cfg channel, always
// ready, and must only be written while the engine is idle.
module lfu_cache_engine_core #(
	parameter int MAX_ENTRIES = 16,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  lfu_pkg::cap_t        active_capacity,
	// request
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 opcode,
	input  lfu_pkg::word_t       req_key,
	input  lfu_pkg::word_t       req_value,
	// result
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 hit,
	output lfu_pkg::word_t       read_value,
	output logic                 evicted,
	output lfu_pkg::word_t       evicted_key
);

	localparam int RW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1; // rank / index
	localparam int FW   = $clog2(MAX_ENTRIES + 1);                      // fill count
	localparam int CMPW = (FW > 5) ? FW : 5;
	localparam int P    = 1 << RW;                                      // tree leaves
	localparam logic [CMPW-1:0] MAX_CAP = CMPW'(MAX_ENTRIES);

	// ---------------- state ----------------
	logic [MAX_ENTRIES-1:0] entry_valid_q;
	lfu_pkg::word_t         entry_key_q   [MAX_ENTRIES];
	lfu_pkg::word_t         entry_value_q [MAX_ENTRIES];
	logic [COUNT_WIDTH-1:0] entry_cnt_q   [MAX_ENTRIES];
	logic [RW-1:0]          entry_rank_q  [MAX_ENTRIES];
	logic [FW-1:0]          fill_q;
	lfu_pkg::cap_t          cap_q;

	// input stage
	logic                   valid_s1;
	logic                   op_s1;
	lfu_pkg::word_t         key_s1;
	lfu_pkg::word_t         value_s1;

	// result stage
	logic                   out_valid_q;
	logic                   hit_q;
	lfu_pkg::word_t         read_value_q;
	logic                   evicted_q;
	lfu_pkg::word_t         evicted_key_q;

	logic adv;
	assign adv       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;

	// ---------------- capacity ----------------
	logic [CMPW-1:0] cap_eff;
	logic            cap_nz;
	logic            fill_lt_cap;
	always_comb begin
		cap_eff     = (CMPW'(cap_q) > MAX_CAP) ? MAX_CAP : CMPW'(cap_q);
		cap_nz      = (cap_q != '0);
		fill_lt_cap = (CMPW'(fill_q) < cap_eff);
	end

	// ---------------- lookup ----------------
	logic [MAX_ENTRIES-1:0] match;
	logic                   found;
	lfu_pkg::word_t         hit_value;
	logic [RW-1:0]          hit_rank;
	logic [RW-1:0]          free_idx;
	always_comb begin
		hit_value = '0;
		hit_rank  = '0;
		free_idx  = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			match[i] = entry_valid_q[i] && (entry_key_q[i] == key_s1);
		end
		found = cap_nz && (|match);
		// keys are unique among valid entries, so match is one-hot
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			hit_value = hit_value | (match[i] ? entry_value_q[i] : '0);
			hit_rank  = hit_rank  | (match[i] ? entry_rank_q[i]  : '0);
		end
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (!entry_valid_q[i]) begin
				free_idx = RW'(i);
			end
		end
	end

	// ---------------- victim tree ----------------
	// heap layout: node n has children 2n+1 and 2n+2, leaves at P-1..2P-2
	logic                   nd_vld  [2*P-1];
	logic [COUNT_WIDTH-1:0] nd_cnt  [2*P-1];
	logic [RW-1:0]          nd_rank [2*P-1];
	logic [RW-1:0]          nd_idx  [2*P-1];
	lfu_pkg::word_t         nd_key  [2*P-1];

	for (genvar g = 0; g < P; g++) begin : g_leaf
		if (g < MAX_ENTRIES) begin : g_used
			assign nd_vld [P-1+g] = entry_valid_q[g];
			assign nd_cnt [P-1+g] = entry_cnt_q[g];
			assign nd_rank[P-1+g] = entry_rank_q[g];
			assign nd_key [P-1+g] = entry_key_q[g];
		end else begin : g_pad
			assign nd_vld [P-1+g] = 1'b0;
			assign nd_cnt [P-1+g] = '0;
			assign nd_rank[P-1+g] = '0;
			assign nd_key [P-1+g] = '0;
		end
		assign nd_idx[P-1+g] = RW'(g);
	end

	for (genvar n = 0; n < P - 1; n++) begin : g_node
		logic take_left;
		always_comb begin
			take_left = nd_vld[2*n+1] && (!nd_vld[2*n+2] ||
				(nd_cnt[2*n+1] < nd_cnt[2*n+2]) ||
				((nd_cnt[2*n+1] == nd_cnt[2*n+2]) && (nd_rank[2*n+1] > nd_rank[2*n+2])));
		end
		assign nd_vld [n] = nd_vld[2*n+1] || nd_vld[2*n+2];
		assign nd_cnt [n] = take_left ? nd_cnt [2*n+1] : nd_cnt [2*n+2];
		assign nd_rank[n] = take_left ? nd_rank[2*n+1] : nd_rank[2*n+2];
		assign nd_idx [n] = take_left ? nd_idx [2*n+1] : nd_idx [2*n+2];
		assign nd_key [n] = take_left ? nd_key [2*n+1] : nd_key [2*n+2];
	end

	// ---------------- update control ----------------
	logic                   do_bump;   // hit on get or set
	logic                   do_ins;    // set miss with nonzero capacity
	logic                   do_evict;
	logic [RW-1:0]          ins_idx;
	logic [RW-1:0]          old_rank;
	logic [MAX_ENTRIES-1:0] sel;
	always_comb begin
		do_bump  = adv && found;
		do_ins   = adv && (op_s1 == lfu_pkg::OP_SET) && !found && cap_nz;
		do_evict = do_ins && !fill_lt_cap;
		ins_idx  = fill_lt_cap ? free_idx : nd_idx[0];
		if (found) begin
			old_rank = hit_rank;
		end else if (fill_lt_cap) begin
			old_rank = fill_q[RW-1:0];
		end else begin
			old_rank = nd_rank[0];
		end
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			sel[i] = found ? match[i] : (ins_idx == RW'(i));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			fill_q        <= '0;
		end else begin
			if (do_ins) begin
				entry_valid_q <= entry_valid_q | sel;
				if (fill_lt_cap) begin
					fill_q <= fill_q + FW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (do_bump || do_ins) begin
				// promote the touched entry, age the ones that were newer
				if (sel[i]) begin
					entry_rank_q[i] <= '0;
				end else if (entry_valid_q[i] && (entry_rank_q[i] < old_rank)) begin
					entry_rank_q[i] <= entry_rank_q[i] + RW'(1);
				end
			end
			if (sel[i]) begin
				if (do_bump) begin
					if (entry_cnt_q[i] != {COUNT_WIDTH{1'b1}}) begin
						entry_cnt_q[i] <= entry_cnt_q[i] + COUNT_WIDTH'(1);
					end
					if (op_s1 == lfu_pkg::OP_SET) begin
						entry_value_q[i] <= value_s1;
					end
				end else if (do_ins) begin
					entry_cnt_q[i]   <= COUNT_WIDTH'(1);
					entry_key_q[i]   <= key_s1;
					entry_value_q[i] <= value_s1;
				end
			end
		end
	end

	// ---------------- capacity register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lfu_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= active_capacity;
		end
	end

	// ---------------- input stage ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1    <= opcode;
			key_s1   <= req_key;
			value_s1 <= req_value;
		end
	end

	// ---------------- result stage ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q         <= found;
			evicted_q     <= do_evict;
			evicted_key_q <= do_evict ? nd_key[0] : lfu_pkg::ZERO_WORD;
			if (op_s1 == lfu_pkg::OP_SET) begin
				read_value_q <= lfu_pkg::ZERO_WORD;
			end else if (found) begin
				read_value_q <= hit_value;
			end else begin
				read_value_q <= lfu_pkg::MISS_VALUE;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign read_value  = read_value_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;

	// ---------------- assertions ----------------
	a_fill_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(entry_valid_q) == int'(fill_q))
		else $error("fill count out of step with valid entries");

	a_evict_is_set_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && evicted |-> !hit && (read_value == lfu_pkg::ZERO_WORD))
		else $error("eviction reported on a hit or a get");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled while a stage was free");

	a_zero_cap_no_fill: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !cap_nz |=> $stable(fill_q) && $stable(entry_valid_q))
		else $error("cache state changed with capacity zero");

endmodule
